// ----- rtl/core/gwm_pkg.sv -----
// ----------------------------------------------------------------------------
// gwm_pkg: shared definitions for the glob wildcard matcher
// Symbol codes, field widths, default sizes and configuration register map.
// ----------------------------------------------------------------------------
`default_nettype none

package gwm_pkg;

    // Field widths fixed by the interface
    localparam int SYM_W        = 4;
    localparam int DIGIT_W      = 4;
    localparam int PAT_FIELD_W  = 64;
    localparam int PLEN_FIELD_W = 5;
    localparam int KEY_FIELD_W  = 52;
    localparam int KLEN_FIELD_W = 4;
    localparam int CFG_IDX_W    = 1;

    // Default sizes
    localparam int PATTERN_MAX_DEF = 16;
    localparam int KEY_MAX_DEF     = 13;

    // Pattern symbol codes (12..15 never match)
    localparam logic [SYM_W-1:0] SYM_DIGIT_MAX = 4'd9;
    localparam logic [SYM_W-1:0] SYM_ANY       = 4'd10;
    localparam logic [SYM_W-1:0] SYM_STAR      = 4'd11;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_SYMBOLS = 1'b0,
        REG_PATTERN_LENGTH  = 1'b1
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/core/gwm_pattern.sv -----
// ----------------------------------------------------------------------------
// gwm_pattern: pattern registers and decode
// Holds the pattern, decodes per-position masks and the star reach matrix.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_pattern #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     cfg_valid,
    input  wire logic [gwm_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  wire logic [gwm_pkg::PAT_FIELD_W-1:0]          cfg_data,
    output logic [PATTERN_MAX-1:0][gwm_pkg::SYM_W-1:0]    pat_sym,
    output logic [PATTERN_MAX-1:0]                        star_mask,
    output logic [PATTERN_MAX-1:0]                        any_mask,
    output logic [PATTERN_MAX-1:0]                        lit_mask,
    output logic [PATTERN_MAX:0][PATTERN_MAX:0]           reach,
    output logic [$clog2(PATTERN_MAX+1)-1:0]              plen
);

    localparam int PIDX_W = $clog2(PATTERN_MAX + 1);

    logic [gwm_pkg::PAT_FIELD_W-1:0]  symbols_reg, symbols_next;
    logic [gwm_pkg::PLEN_FIELD_W-1:0] length_reg, length_next;
    logic [gwm_pkg::PLEN_FIELD_W-1:0] length_sat;

    always_comb begin
        symbols_next = symbols_reg;
        length_next  = length_reg;
        if (cfg_valid) begin
            unique case (gwm_pkg::cfg_reg_t'(cfg_index))
                gwm_pkg::REG_PATTERN_SYMBOLS: symbols_next = cfg_data;
                gwm_pkg::REG_PATTERN_LENGTH:
                    length_next = cfg_data[gwm_pkg::PLEN_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbols_reg <= '0;
            length_reg  <= '0;
        end else begin
            symbols_reg <= symbols_next;
            length_reg  <= length_next;
        end
    end

    // Saturate length to the pattern capacity
    assign length_sat = (length_reg > gwm_pkg::PLEN_FIELD_W'(PATTERN_MAX))
                        ? gwm_pkg::PLEN_FIELD_W'(PATTERN_MAX) : length_reg;
    assign plen = PIDX_W'(length_sat);

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            pat_sym[i]   = symbols_reg[i*gwm_pkg::SYM_W +: gwm_pkg::SYM_W];
            star_mask[i] = (gwm_pkg::PLEN_FIELD_W'(i) < length_sat) &&
                           (pat_sym[i] == gwm_pkg::SYM_STAR);
            any_mask[i]  = (gwm_pkg::PLEN_FIELD_W'(i) < length_sat) &&
                           (pat_sym[i] == gwm_pkg::SYM_ANY);
            lit_mask[i]  = (gwm_pkg::PLEN_FIELD_W'(i) < length_sat) &&
                           (pat_sym[i] <= gwm_pkg::SYM_DIGIT_MAX);
        end
    end

    // reach[k][i]: position k is reachable from i through stars only,
    // i.e. every symbol from i to k-1 is a star (k itself always).
    always_comb begin
        logic [PATTERN_MAX-1:0] span;
        span = '0;
        for (int k = 0; k <= PATTERN_MAX; k++) begin
            for (int i = 0; i <= PATTERN_MAX; i++) begin
                if (i == k) begin
                    reach[k][i] = 1'b1;
                end else if (i < k) begin
                    span = ~({PATTERN_MAX{1'b1}} << k) & ({PATTERN_MAX{1'b1}} << i);
                    reach[k][i] = ((star_mask & span) == span);
                end else begin
                    reach[k][i] = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gwm_cell.sv -----
// ----------------------------------------------------------------------------
// gwm_cell: one key-digit step of the matcher chain
// Advances the active position set by one key digit, or passes it through past the key length, and registers it.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_cell #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
    parameter int KEY_MAX     = gwm_pkg::KEY_MAX_DEF,
    parameter int IDX         = 0
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     advance,
    input  wire logic [PATTERN_MAX-1:0][gwm_pkg::SYM_W-1:0] pat_sym,
    input  wire logic [PATTERN_MAX-1:0]                   star_mask,
    input  wire logic [PATTERN_MAX-1:0]                   any_mask,
    input  wire logic [PATTERN_MAX-1:0]                   lit_mask,
    input  wire logic [PATTERN_MAX:0][PATTERN_MAX:0]      reach,
    input  wire logic                                     in_valid,
    input  wire logic [PATTERN_MAX:0]                     in_set,
    input  wire logic [KEY_MAX*gwm_pkg::DIGIT_W-1:0]      in_key,
    input  wire logic [$clog2(KEY_MAX+1)-1:0]             in_klen,
    output logic                                          out_valid,
    output logic [PATTERN_MAX:0]                          out_set,
    output logic [KEY_MAX*gwm_pkg::DIGIT_W-1:0]           out_key,
    output logic [$clog2(KEY_MAX+1)-1:0]                  out_klen
);

    localparam int KLEN_W = $clog2(KEY_MAX + 1);

    logic                          valid_reg, valid_next;
    logic [PATTERN_MAX:0]          set_reg, set_next;
    logic [KEY_MAX*gwm_pkg::DIGIT_W-1:0] key_reg;
    logic [KLEN_W-1:0]             klen_reg;

    logic [gwm_pkg::DIGIT_W-1:0]   digit;
    logic                          active;
    logic [PATTERN_MAX-1:0]        lit_hit;
    logic [PATTERN_MAX:0]          step;
    logic [PATTERN_MAX:0]          closed;

    assign digit  = in_key[IDX*gwm_pkg::DIGIT_W +: gwm_pkg::DIGIT_W];
    assign active = (in_klen > KLEN_W'(IDX));

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            lit_hit[i] = lit_mask[i] && (pat_sym[i] == digit);
        end
    end

    // Star stays, any/literal advances one position
    assign step = {1'b0, in_set[PATTERN_MAX-1:0] & star_mask}
                | {in_set[PATTERN_MAX-1:0] & (any_mask | lit_hit), 1'b0};

    // Star closure in one level: OR over all sources that reach each position
    always_comb begin
        for (int k = 0; k <= PATTERN_MAX; k++) begin
            closed[k] = |(step & reach[k]);
        end
    end

    assign valid_next = in_valid;
    assign set_next   = active ? closed : in_set;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            set_reg  <= set_next;
            key_reg  <= in_key;
            klen_reg <= in_klen;
        end
    end

    assign out_valid = valid_reg;
    assign out_set   = set_reg;
    assign out_key   = key_reg;
    assign out_klen  = klen_reg;

endmodule

`default_nettype wire

// ----- rtl/core/glob_wildcard_match.sv -----
// ----------------------------------------------------------------------------
// glob_wildcard_match: digit-key glob matcher ('?' one digit, '*' any run)
// Each key beat is registered in every cell of the chain, then in the result register.
// Throughput: one key per cycle; the whole chain stalls only while the result
// register is full and m_ready is low.
// Reset: synchronous active-low aresetn empties the chain and result register
// and clears both pattern registers (empty pattern); no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module glob_wildcard_match #(
    parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF,
    parameter int KEY_MAX     = gwm_pkg::KEY_MAX_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // configuration write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [gwm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [gwm_pkg::PAT_FIELD_W-1:0]        cfg_data,
    // key channel
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [gwm_pkg::KEY_FIELD_W-1:0]        s_key_digits,
    input  wire logic [gwm_pkg::KLEN_FIELD_W-1:0]       s_key_length,
    // result channel
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic                                        m_matched
);

    localparam int KLEN_W = $clog2(KEY_MAX + 1);
    localparam int PIDX_W = $clog2(PATTERN_MAX + 1);
    localparam int KEY_W  = KEY_MAX * gwm_pkg::DIGIT_W;
    // key field widened when KEY_MAX asks for more digits than the port has;
    // missing digit slots read as zero
    localparam int EXT_W  = (KEY_W > gwm_pkg::KEY_FIELD_W) ? KEY_W : gwm_pkg::KEY_FIELD_W;

    // Pattern decode
    logic [PATTERN_MAX-1:0][gwm_pkg::SYM_W-1:0] pat_sym;
    logic [PATTERN_MAX-1:0]                     star_mask;
    logic [PATTERN_MAX-1:0]                     any_mask;
    logic [PATTERN_MAX-1:0]                     lit_mask;
    logic [PATTERN_MAX:0][PATTERN_MAX:0]        reach;
    logic [PIDX_W-1:0]                          plen;

    // Chain taps: entry j feeds cell j, entry KEY_MAX is the last cell's output
    logic [KEY_MAX:0]                           tap_valid;
    logic [KEY_MAX:0][PATTERN_MAX:0]            tap_set;
    logic [KEY_MAX:0][KEY_W-1:0]                tap_key;
    logic [KEY_MAX:0][KLEN_W-1:0]               tap_klen;

    logic [EXT_W-1:0]                           key_ext;
    logic [gwm_pkg::PLEN_FIELD_W-1:0]           klen_wide;
    logic [PATTERN_MAX:0]                       start_set;
    logic                                       advance;

    logic                                       m_valid_reg, m_valid_next;
    logic                                       m_matched_reg, m_matched_next;

    // Config writes are always taken
    assign cfg_ready = 1'b1;

    gwm_pattern #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_pattern (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pat_sym   (pat_sym),
        .star_mask (star_mask),
        .any_mask  (any_mask),
        .lit_mask  (lit_mask),
        .reach     (reach),
        .plen      (plen)
    );

    // Whole chain moves together; it holds only when the result beat is stuck
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    // Initial position set: position 0 plus whatever leading stars reach
    always_comb begin
        for (int k = 0; k <= PATTERN_MAX; k++) begin
            start_set[k] = reach[k][0];
        end
    end

    // Key length saturates at KEY_MAX
    assign klen_wide = ({1'b0, s_key_length} > gwm_pkg::PLEN_FIELD_W'(KEY_MAX))
                       ? gwm_pkg::PLEN_FIELD_W'(KEY_MAX) : {1'b0, s_key_length};
    assign key_ext   = EXT_W'(s_key_digits);

    assign tap_valid[0] = s_valid;
    assign tap_set[0]   = start_set;
    assign tap_key[0]   = key_ext[KEY_W-1:0];
    assign tap_klen[0]  = KLEN_W'(klen_wide);

    // One cell per key digit; cells past the key length pass the set through
    for (genvar j = 0; j < KEY_MAX; j++) begin : g_cell
        gwm_cell #(
            .PATTERN_MAX (PATTERN_MAX),
            .KEY_MAX     (KEY_MAX),
            .IDX         (j)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .pat_sym   (pat_sym),
            .star_mask (star_mask),
            .any_mask  (any_mask),
            .lit_mask  (lit_mask),
            .reach     (reach),
            .in_valid  (tap_valid[j]),
            .in_set    (tap_set[j]),
            .in_key    (tap_key[j]),
            .in_klen   (tap_klen[j]),
            .out_valid (tap_valid[j+1]),
            .out_set   (tap_set[j+1]),
            .out_key   (tap_key[j+1]),
            .out_klen  (tap_klen[j+1])
        );
    end

    // Result register: match when the end-of-pattern position is active.
    // The last cell's key and length taps end here unread.
    always_comb begin
        m_valid_next   = m_valid_reg;
        m_matched_next = m_matched_reg;
        if (advance) begin
            m_valid_next   = tap_valid[KEY_MAX];
            m_matched_next = tap_set[KEY_MAX][plen];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_matched_reg <= m_matched_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_matched = m_matched_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gwm_checker.sv -----
// ----------------------------------------------------------------------------
// gwm_checker: port-level checks for the glob matcher
// Watches the handshakes at the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module gwm_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic cfg_ready,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_matched
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_matched))
        else $error("result beat dropped or changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input is refused only while a result beat is stuck
    a_ready_link: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("key channel ready does not follow result stall");

    // Config channel never pushes back
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind glob_wildcard_match gwm_checker u_gwm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_ready (cfg_ready),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_matched (m_matched)
);

`default_nettype wire
